[design/spg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spg_pkg;

    localparam int GRID_SIZE_DEF = 64;
    localparam int CNT_W         = 32;
    localparam int COORD_W       = 6;
    localparam int SWEEP_W       = 16;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // neighbourhood around the centre tap of the line
    typedef struct packed {
        logic [CNT_W-1:0] up_share;
        logic [CNT_W-1:0] down_share;
        logic [CNT_W-1:0] left_share;
        logic [CNT_W-1:0] right_share;
        logic [CNT_W-1:0] ctr_val;
        logic [CNT_W-1:0] ctr_keep;
    } win_t;

endpackage
`default_nettype wire

[design/sandpile_toppling_grid.sv]
`timescale 1ns / 1ps
`default_nettype none
// Write, bad-address and unused-opcode requests: result valid in the cycle after accept.
// Read request: address and memory data are registered in turn before the result.
// Run request: sweep_count sweeps, each streaming the grid memory (one read, one write port)
// through the cell line. One request in flight at a time. Reset is synchronous, active low;
// it clears all 2**(clog2(N*N)+1) memory words (8192 for N = 64), no requests taken.
module sandpile_toppling_grid #(
    parameter int GRID_SIZE = spg_pkg::GRID_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // col[5:0], row[11:6], cell_value[43:12], sweep_count[59:44]
    input  wire logic [63:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_value[31:0]
    output logic [31:0]      m_tdata,
    // op_done[0]
    output logic [0:0]       m_tuser
);
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int IDX_W = $clog2(CELLS);
    localparam int AW    = IDX_W + 1;
    localparam int RC_W  = $clog2(GRID_SIZE);
    localparam int T_W   = $clog2(CELLS + GRID_SIZE + 2);
    localparam logic [T_W-1:0]  T_FIRST = T_W'(GRID_SIZE + 2);
    localparam logic [T_W-1:0]  T_LAST  = T_W'(CELLS + GRID_SIZE + 1);
    localparam logic [T_W-1:0]  T_CELLS = T_W'(CELLS);
    localparam logic [RC_W-1:0] RC_ONE  = RC_W'(1);
    localparam logic [RC_W-1:0] RC_TWO  = RC_W'(2);
    localparam logic [RC_W-1:0] RC_NM1  = RC_W'(GRID_SIZE - 1);
    localparam logic [RC_W-1:0] RC_NM2  = RC_W'(GRID_SIZE - 2);
    localparam logic [RC_W-1:0] RC_NM3  = RC_W'(GRID_SIZE - 3);

    spg_pkg::state_t state_reg, state_next;
    logic                        bank_reg, bank_next;
    logic [AW-1:0]               clr_reg;
    logic [T_W-1:0]              t_reg;
    logic [spg_pkg::SWEEP_W-1:0] sweeps_reg;
    logic [IDX_W-1:0]            addr_reg;
    logic [IDX_W-1:0]            out_idx_reg;
    logic [RC_W-1:0]             out_row_reg, out_col_reg;
    logic                        m_tvalid_reg;
    logic [spg_pkg::CNT_W-1:0]   rd_val_reg;
    logic                        done_reg;
    logic [spg_pkg::CNT_W-1:0]   rdata_reg;

    logic [spg_pkg::CNT_W-1:0]   mem [0:(2**AW)-1];
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr, mem_raddr;
    logic [spg_pkg::CNT_W-1:0]   mem_wdata;

    logic                        load_out, ld_done, accept, slot_free;
    logic [spg_pkg::CNT_W-1:0]   ld_val;

    logic [spg_pkg::COORD_W-1:0] in_col, in_row;
    logic [spg_pkg::CNT_W-1:0]   in_value;
    logic [spg_pkg::SWEEP_W-1:0] in_sweeps;
    logic                        in_inside;
    logic [IDX_W-1:0]            in_idx;

    logic                        s_valid, sweep_last;
    logic [IDX_W-1:0]            sw_raddr;
    logic                        r_in, c_in, up_ok, dn_ok, lf_ok, rt_ok;
    logic [spg_pkg::CNT_W-1:0]   new_val;
    spg_pkg::win_t               win;

    assign in_col    = s_tdata[5:0];
    assign in_row    = s_tdata[11:6];
    assign in_value  = s_tdata[43:12];
    assign in_sweeps = s_tdata[59:44];
    assign in_inside = (32'(in_col) < 32'(GRID_SIZE)) && (32'(in_row) < 32'(GRID_SIZE));
    assign in_idx    = IDX_W'(32'(in_row) * 32'(GRID_SIZE) + 32'(in_col));

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == spg_pkg::ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;

    spg_line #(.GRID_SIZE(GRID_SIZE)) u_line (
        .aclk (aclk),
        .d_in (rdata_reg),
        .win  (win)
    );

    // centre tap holds cell t - 2 - N
    assign s_valid    = (t_reg >= T_FIRST) && (t_reg <= T_LAST);
    assign sweep_last = (t_reg == T_LAST);
    assign sw_raddr   = (t_reg < T_CELLS) ? t_reg[IDX_W-1:0] : '0;

    // a neighbour only gives grains if it is an interior cell itself
    assign r_in  = (out_row_reg >= RC_ONE) && (out_row_reg <= RC_NM2);
    assign c_in  = (out_col_reg >= RC_ONE) && (out_col_reg <= RC_NM2);
    assign up_ok = (out_row_reg >= RC_TWO) && c_in;
    assign dn_ok = (out_row_reg <= RC_NM3) && c_in;
    assign lf_ok = r_in && (out_col_reg >= RC_TWO);
    assign rt_ok = r_in && (out_col_reg <= RC_NM3);

    assign new_val = ((r_in && c_in) ? win.ctr_keep : win.ctr_val)
                   + (up_ok ? win.up_share    : '0)
                   + (dn_ok ? win.down_share  : '0)
                   + (lf_ok ? win.left_share  : '0)
                   + (rt_ok ? win.right_share : '0);

    always_comb begin
        state_next = state_reg;
        bank_next  = bank_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = '0;
        mem_raddr  = {bank_reg, addr_reg};
        load_out   = 1'b0;
        ld_val     = '0;
        ld_done    = 1'b0;
        case (state_reg)
            spg_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                if (&clr_reg) state_next = spg_pkg::ST_IDLE;
            end
            spg_pkg::ST_IDLE: begin
                if (accept) begin
                    case (spg_pkg::op_t'(s_tuser))
                        spg_pkg::OP_WRITE: begin
                            mem_we    = in_inside;
                            mem_waddr = {bank_reg, in_idx};
                            mem_wdata = in_value;
                            load_out  = 1'b1;
                            ld_done   = in_inside;
                        end
                        spg_pkg::OP_RUN: begin
                            if (in_sweeps == '0) begin
                                load_out = 1'b1;
                                ld_done  = 1'b1;
                            end else begin
                                state_next = spg_pkg::ST_SWEEP;
                            end
                        end
                        spg_pkg::OP_READ: begin
                            if (in_inside) state_next = spg_pkg::ST_RD_ADDR;
                            else load_out = 1'b1;
                        end
                        default: load_out = 1'b1;
                    endcase
                end
            end
            spg_pkg::ST_RD_ADDR: state_next = spg_pkg::ST_RD_DATA;
            spg_pkg::ST_RD_DATA: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    ld_val     = rdata_reg;
                    ld_done    = 1'b1;
                    state_next = spg_pkg::ST_IDLE;
                end
            end
            spg_pkg::ST_SWEEP: begin
                mem_raddr = {bank_reg, sw_raddr};
                mem_we    = s_valid;
                mem_waddr = {~bank_reg, out_idx_reg};
                mem_wdata = new_val;
                if (sweep_last) begin
                    bank_next = ~bank_reg;
                    if (sweeps_reg == spg_pkg::SWEEP_W'(1)) state_next = spg_pkg::ST_DONE;
                end
            end
            spg_pkg::ST_DONE: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    ld_done    = 1'b1;
                    state_next = spg_pkg::ST_IDLE;
                end
            end
            default: state_next = spg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= spg_pkg::ST_CLEAR;
            bank_reg     <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            t_reg        <= '0;
        end else begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            if (state_reg == spg_pkg::ST_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (load_out) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            if (state_reg != spg_pkg::ST_SWEEP || sweep_last) t_reg <= '0;
            else t_reg <= t_reg + T_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg   <= in_idx;
            sweeps_reg <= in_sweeps;
        end else if (state_reg == spg_pkg::ST_SWEEP && sweep_last) begin
            sweeps_reg <= sweeps_reg - spg_pkg::SWEEP_W'(1);
        end
        if (state_reg != spg_pkg::ST_SWEEP || sweep_last) begin
            out_idx_reg <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else if (s_valid) begin
            out_idx_reg <= out_idx_reg + IDX_W'(1);
            if (out_col_reg == RC_NM1) begin
                out_col_reg <= '0;
                out_row_reg <= out_row_reg + RC_ONE;
            end else begin
                out_col_reg <= out_col_reg + RC_ONE;
            end
        end
        if (load_out) begin
            rd_val_reg <= ld_val;
            done_reg   <= ld_done;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = rd_val_reg;
    assign m_tuser[0] = done_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> slot_free) else $error("result overwritten while pending");
    a_bank_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spg_pkg::ST_SWEEP && sweep_last) |=> (bank_reg != $past(bank_reg)))
        else $error("bank not flipped at end of sweep");
    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spg_pkg::ST_CLEAR) |-> !s_tready) else $error("request taken while clearing");
    a_sweep_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spg_pkg::ST_SWEEP && mem_we) |-> (mem_waddr[AW-1] != bank_reg))
        else $error("sweep writes into current bank");
endmodule
`default_nettype wire

[design/spg_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module spg_cell (
    input  wire logic                     aclk,
    input  wire logic [spg_pkg::CNT_W-1:0] d_in,
    output logic      [spg_pkg::CNT_W-1:0] val,
    output logic      [spg_pkg::CNT_W-1:0] share,
    output logic      [spg_pkg::CNT_W-1:0] keep
);
    logic [spg_pkg::CNT_W-1:0] val_reg;
    logic                      topple;

    always_ff @(posedge aclk) begin
        val_reg <= d_in;
    end

    assign topple = (val_reg[spg_pkg::CNT_W-1:2] != '0);
    assign val    = val_reg;
    assign share  = topple ? {2'b00, val_reg[spg_pkg::CNT_W-1:2]} : '0;
    assign keep   = topple ? {{(spg_pkg::CNT_W-2){1'b0}}, val_reg[1:0]} : val_reg;
endmodule
`default_nettype wire

[design/spg_line.sv]
`timescale 1ns / 1ps
`default_nettype none
module spg_line #(
    parameter int GRID_SIZE = spg_pkg::GRID_SIZE_DEF
) (
    input  wire logic                      aclk,
    input  wire logic [spg_pkg::CNT_W-1:0] d_in,
    output spg_pkg::win_t                  win
);
    localparam int DEPTH = 2 * GRID_SIZE + 1;

    logic [spg_pkg::CNT_W-1:0] val   [0:DEPTH-1];
    logic [spg_pkg::CNT_W-1:0] share [0:DEPTH-1];
    logic [spg_pkg::CNT_W-1:0] keep  [0:DEPTH-1];

    genvar j;
    generate
        for (j = 0; j < DEPTH; j++) begin : g_cell
            if (j == 0) begin : g_head
                spg_cell u_cell (
                    .aclk (aclk), .d_in (d_in),
                    .val (val[j]), .share (share[j]), .keep (keep[j])
                );
            end else begin : g_body
                spg_cell u_cell (
                    .aclk (aclk), .d_in (val[j-1]),
                    .val (val[j]), .share (share[j]), .keep (keep[j])
                );
            end
        end
    endgenerate

    // tap j holds the cell j places behind the newest one
    assign win.down_share  = share[0];
    assign win.right_share = share[GRID_SIZE-1];
    assign win.ctr_val     = val[GRID_SIZE];
    assign win.ctr_keep    = keep[GRID_SIZE];
    assign win.left_share  = share[GRID_SIZE+1];
    assign win.up_share    = share[2*GRID_SIZE];
endmodule
`default_nettype wire
